/* rtl/integer_matrix_multiply_macros.svh */
// Assertion macros shared by the integer matrix multiply RTL.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define IMM_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define IMM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/imm_pkg.sv */
// Types and constants shared by the integer matrix multiply modules.
package imm_pkg;

    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 5;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_WRITE_A,
        ACT_WRITE_B,
        ACT_EMIT
    } imm_action_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [DATA_W-1:0] element_value;
    } imm_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] out_value;
        logic                     row_last;
    } imm_out_t;

    // One element of a row of A travelling down the chain of cells.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [SIZE_W-1:0] k;
        logic [DATA_W-1:0] a;
    } imm_chain_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic              b_we;
        logic [IDX_W-1:0]  b_row;
        logic [IDX_W-1:0]  b_col;
        logic [DATA_W-1:0] b_data;
        logic [SIZE_W-1:0] size;
    } imm_ctrl_t;

endpackage

/* rtl/imm_cell.sv */
// One multiply-accumulate cell that owns a single column of B.
`include "integer_matrix_multiply_macros.svh"

module imm_cell #(
    parameter int MAX_SIZE = 16,
    parameter int COL      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  imm_pkg::imm_ctrl_t           ctrl,
    input  imm_pkg::imm_chain_t          chain_in,
    output imm_pkg::imm_chain_t          chain_out,
    input  logic [imm_pkg::DATA_W-1:0]   res_in,
    output logic [imm_pkg::DATA_W-1:0]   res_out,
    output logic                         done
);
    import imm_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [DATA_W-1:0] b_mem [MAX_SIZE];
    logic [DATA_W-1:0] b_rd_reg;

    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [SIZE_W-1:0] s1_k_reg;
    logic [DATA_W-1:0] s1_a_reg;

    logic              p_valid_reg;
    logic              p_first_reg;
    logic              p_last_reg;
    logic [DATA_W-1:0] prod_reg;

    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] res_reg;
    logic              done_reg;
    logic [DATA_W-1:0] acc_sum;

    // Column store of B, addressed by row, read at the k carried by the chain.
    always_ff @(posedge clk)
    begin
        if (ctrl.b_we && (int'(ctrl.b_col) == COL))
        begin
            b_mem[IW'(ctrl.b_row)] <= ctrl.b_data;
        end
        b_rd_reg <= b_mem[IW'(chain_in.k)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_k_reg     <= '0;
            s1_a_reg     <= '0;
            p_valid_reg  <= 1'b0;
            p_first_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            res_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            // Cells beyond the active size stay quiet.
            s1_valid_reg <= chain_in.valid && (COL < int'(ctrl.size));
            s1_first_reg <= chain_in.first;
            s1_last_reg  <= chain_in.last;
            s1_k_reg     <= chain_in.k;
            s1_a_reg     <= chain_in.a;

            p_valid_reg <= s1_valid_reg;
            p_first_reg <= s1_first_reg;
            p_last_reg  <= s1_last_reg;
            prod_reg    <= s1_a_reg * b_rd_reg;

            if (p_valid_reg)
            begin
                acc_reg <= acc_sum;
            end

            if (ctrl.shift)
            begin
                res_reg <= res_in;
            end
            else if (p_valid_reg && p_last_reg)
            begin
                res_reg <= acc_sum;
            end

            if (ctrl.clear)
            begin
                done_reg <= 1'b0;
            end
            else if (p_valid_reg && p_last_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign acc_sum = (p_first_reg ? '0 : acc_reg) + prod_reg;

    assign chain_out.valid = s1_valid_reg;
    assign chain_out.first = s1_first_reg;
    assign chain_out.last  = s1_last_reg;
    assign chain_out.k     = s1_k_reg;
    assign chain_out.a     = s1_a_reg;

    assign res_out = res_reg;
    assign done    = done_reg;

    `IMM_CHECK_NEXT(a_clear_drops_done, ctrl.clear, !done_reg,
        "done flag survived the start of a new row")
    `IMM_CHECK_NEXT(a_last_sets_done, p_valid_reg && p_last_reg && !ctrl.clear, done_reg,
        "final accumulation did not mark the cell done")
    `IMM_CHECK_NOW(a_no_mac_while_unload, ctrl.shift, !p_valid_reg,
        "a product was still in flight while results were shifted out")

endmodule

/* rtl/integer_matrix_multiply.sv */
// Top level of the integer matrix multiply: store of A, sequencer and chain of cells.
// An emit of row r with effective size n feeds row r of A through the chain of cells and,
// once the last active cell is done, gives one result per cycle while out_stall is low;
// new input is stalled until the row has been unloaded.
// Reset clears control state and sets the active size to 16; matrix stores are
// not cleared and hold undefined data until written.
`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply #(
    parameter int MAX_SIZE = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  imm_pkg::imm_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output imm_pkg::imm_out_t           out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [imm_pkg::SIZE_W-1:0]  cfg_data
);
    import imm_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_UNLOAD
    } state_t;

    state_t            state_reg;
    logic [SIZE_W-1:0] active_size_reg;
    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] n_last;
    logic [SIZE_W-1:0] k_reg;
    logic [SIZE_W-1:0] col_reg;
    logic [IW-1:0]     row_reg;

    logic              f_valid_reg;
    logic              f_first_reg;
    logic              f_last_reg;
    logic [SIZE_W-1:0] f_k_reg;
    logic [DATA_W-1:0] a_rd_reg;

    logic              out_valid_reg;
    imm_out_t          out_data_reg;

    logic [DATA_W-1:0] a_mem [MAX_SIZE][MAX_SIZE];

    logic              in_accept;
    logic              in_bounds;
    logic              is_emit;
    logic              a_we;
    logic              load;
    imm_ctrl_t         ctrl;

    imm_chain_t        chain [MAX_SIZE+1];
    logic [DATA_W-1:0] res_vec [MAX_SIZE+1];
    logic [MAX_SIZE-1:0] done_vec;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= ACTIVE_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_size_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (active_size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (int'(active_size_reg) > MAX_SIZE)
        begin
            n_eff = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            n_eff = active_size_reg;
        end
    end

    assign n_last = n_eff - SIZE_W'(1);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_bounds = (int'(in_data.row_index) < MAX_SIZE)
                       && (int'(in_data.col_index) < MAX_SIZE);
    assign is_emit   = in_accept && (in_data.action == ACT_EMIT)
                       && ({1'b0, in_data.row_index} < n_eff);
    assign a_we      = in_accept && (in_data.action == ACT_WRITE_A) && in_bounds;
    assign load      = (state_reg == ST_UNLOAD) && (!out_valid_reg || !out_stall);

    assign ctrl.clear  = is_emit;
    assign ctrl.shift  = load;
    assign ctrl.b_we   = in_accept && (in_data.action == ACT_WRITE_B) && in_bounds;
    assign ctrl.b_row  = in_data.row_index;
    assign ctrl.b_col  = in_data.col_index;
    assign ctrl.b_data = in_data.element_value;
    assign ctrl.size   = n_eff;

    // Store of A, read one element of the selected row per cycle while feeding.
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[IW'(in_data.row_index)][IW'(in_data.col_index)] <= in_data.element_value;
        end
        a_rd_reg <= a_mem[row_reg][IW'(k_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            f_valid_reg   <= 1'b0;
            f_first_reg   <= 1'b0;
            f_last_reg    <= 1'b0;
            f_k_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // These flags line up with the registered read of A.
            f_valid_reg <= (state_reg == ST_FEED);
            f_first_reg <= (k_reg == '0);
            f_last_reg  <= (k_reg == n_last);
            f_k_reg     <= k_reg;

            if (load)
            begin
                out_valid_reg         <= 1'b1;
                out_data_reg.out_col  <= col_reg[IDX_W-1:0];
                out_data_reg.out_value <= res_vec[0];
                out_data_reg.row_last <= (col_reg == n_last);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (is_emit)
                    begin
                        row_reg   <= IW'(in_data.row_index);
                        k_reg     <= '0;
                        state_reg <= ST_FEED;
                    end
                end
                ST_FEED:
                begin
                    k_reg <= k_reg + SIZE_W'(1);
                    if (k_reg == n_last)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (done_vec[IW'(n_last)])
                    begin
                        col_reg   <= '0;
                        state_reg <= ST_UNLOAD;
                    end
                end
                ST_UNLOAD:
                begin
                    if (load)
                    begin
                        col_reg <= col_reg + SIZE_W'(1);
                        if (col_reg == n_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign chain[0].valid = f_valid_reg;
    assign chain[0].first = f_first_reg;
    assign chain[0].last  = f_last_reg;
    assign chain[0].k     = f_k_reg;
    assign chain[0].a     = a_rd_reg;

    // Results shift toward cell 0, which feeds the output register.
    assign res_vec[MAX_SIZE] = '0;

    for (genvar j = 0; j < MAX_SIZE; j++)
    begin : g_cell
        imm_cell #(
            .MAX_SIZE (MAX_SIZE),
            .COL      (j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .chain_in  (chain[j]),
            .chain_out (chain[j+1]),
            .res_in    (res_vec[j+1]),
            .res_out   (res_vec[j]),
            .done      (done_vec[j])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `IMM_CHECK_NOW(a_unload_all_done, state_reg == ST_UNLOAD, done_vec[IW'(n_last)],
        "results were unloaded before the last active cell finished")
    `IMM_CHECK_NOW(a_unload_col_range, state_reg == ST_UNLOAD, col_reg < n_eff,
        "unload column ran past the active size")
    `IMM_CHECK_NOW(a_feed_only_when_busy, f_valid_reg,
        (state_reg == ST_FEED) || (state_reg == ST_WAIT),
        "an element of A entered the chain outside a row computation")
    `IMM_CHECK_NEXT(a_row_end_leaves_unload, load && (col_reg == n_last),
        state_reg != ST_UNLOAD, "a row was still unloading after its final transaction")

endmodule

/* test/tb_integer_matrix_multiply.sv */
// Testbench for the integer matrix multiply: directed and random matrix traffic with a row scoreboard.
`timescale 1ns / 100ps

module tb_integer_matrix_multiply;
    import imm_pkg::*;

    localparam int DIM           = 16;
    localparam int CELLS         = DIM * DIM;
    localparam int SETTLE_CYCLES = 3 * DIM + 12;
    localparam int IDLE_LIMIT    = 2000;

    localparam logic [1:0]        ACT_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] MAX_POS    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG    = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ALL_ONES   = {DATA_W{1'b1}};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    imm_in_t           in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    imm_out_t          out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;

    // Shadow copy of both matrix stores and of the size register.
    logic [DATA_W-1:0] a_words [CELLS];
    logic [DATA_W-1:0] b_words [CELLS];
    logic [SIZE_W-1:0] size_reg = ACTIVE_SIZE_RESET;
    bit                a_set [CELLS];
    bit                b_set [CELLS];
    imm_out_t          expected_c_elems [$];

    int         burst_left   = 0;
    int         gap_limit    = 0;
    int         stall_pct    = 0;
    int         mismatches   = 0;
    int         items_sent   = 0;
    int         results_seen = 0;
    int         size_writes  = 0;
    int         idle_cycles  = 0;
    logic [7:0] stall_phase  = '0;

    always #5 clk = ~clk;

    integer_matrix_multiply #(
        .MAX_SIZE(DIM)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    function automatic int eff_size(input logic [SIZE_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > DIM)
            return DIM;
        return int'(value);
    endfunction

    // Updates the shadow stores and queues the row of C that an emit produces.
    function automatic void apply_matrix_item(input imm_in_t item);
        int n;
        int r;
        logic [DATA_W-1:0] acc;
        imm_out_t elem;
        n = eff_size(size_reg);
        r = int'(item.row_index);
        case (item.action)
            ACT_WRITE_A: a_words[r * DIM + int'(item.col_index)] = item.element_value;
            ACT_WRITE_B: b_words[r * DIM + int'(item.col_index)] = item.element_value;
            ACT_EMIT:
            begin
                if (r < n)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < n; k++)
                            acc = acc + a_words[r * DIM + k] * b_words[k * DIM + j];
                        elem.out_col   = IDX_W'(j);
                        elem.out_value = acc;
                        elem.row_last  = (j == n - 1);
                        expected_c_elems.push_back(elem);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void report_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return MAX_POS;
            1:       return MIN_NEG;
            2:       return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit row_ready(input int r, input int n);
        for (int k = 0; k < n; k++)
            if (!a_set[r * DIM + k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit b_filled(input int n);
        for (int i = 0; i < CELLS; i++)
            if (i / DIM < n && i % DIM < n && !b_set[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Mostly well-formed traffic: fill the entries that the active size needs,
    // emit rows whose operands are all written, plus some noise.
    function automatic imm_in_t pick_item(input int n);
        imm_in_t item;
        int roll;
        int ready [$];
        int b_miss;
        int a_miss;
        int start;
        int idx;
        item.action        = ACT_WRITE_A;
        item.row_index     = IDX_W'($urandom_range(0, DIM - 1));
        item.col_index     = IDX_W'($urandom_range(0, DIM - 1));
        item.element_value = rand_value();
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            item.action = ACT_UNUSED;
            return item;
        end
        if (roll < 10 && n < DIM)
        begin
            item.action    = ACT_EMIT;
            item.row_index = IDX_W'($urandom_range(n, DIM - 1));
            return item;
        end
        if (roll < 45 && b_filled(n))
        begin
            for (int r = 0; r < n; r++)
                if (row_ready(r, n))
                    ready.push_back(r);
            if (ready.size() > 0)
            begin
                item.action    = ACT_EMIT;
                item.row_index = IDX_W'(ready[$urandom_range(0, ready.size() - 1)]);
                return item;
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            item.action = ($urandom_range(0, 1) != 0) ? ACT_WRITE_B : ACT_WRITE_A;
            return item;
        end
        b_miss = -1;
        start  = $urandom_range(0, CELLS - 1);
        for (int i = 0; i < CELLS; i++)
        begin
            idx = (start + i) % CELLS;
            if (idx / DIM < n && idx % DIM < n && !b_set[idx])
            begin
                b_miss = idx;
                break;
            end
        end
        // A is filled in row order so that rows become ready one after another.
        a_miss = -1;
        for (int i = 0; i < CELLS; i++)
        begin
            if (i / DIM < n && i % DIM < n && !a_set[i])
            begin
                a_miss = i;
                break;
            end
        end
        if (b_miss >= 0 && (a_miss < 0 || $urandom_range(0, 3) != 0))
        begin
            item.action    = ACT_WRITE_B;
            item.row_index = IDX_W'(b_miss / DIM);
            item.col_index = IDX_W'(b_miss % DIM);
        end
        else if (a_miss >= 0)
        begin
            item.action    = ACT_WRITE_A;
            item.row_index = IDX_W'(a_miss / DIM);
            item.col_index = IDX_W'(a_miss % DIM);
        end
        return item;
    endfunction

    task automatic send_item(input imm_in_t item);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            if (gap_limit > 0)
                gap = $urandom_range(0, gap_limit);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        if (item.action == ACT_WRITE_A)
            a_set[int'(item.row_index) * DIM + int'(item.col_index)] = 1'b1;
        else if (item.action == ACT_WRITE_B)
            b_set[int'(item.row_index) * DIM + int'(item.col_index)] = 1'b1;
        apply_matrix_item(item);
        items_sent++;
    endtask

    task automatic send_op(input logic [1:0] action, input int row, input int col,
                           input logic [DATA_W-1:0] value);
        imm_in_t item;
        item.action        = action;
        item.row_index     = IDX_W'(row);
        item.col_index     = IDX_W'(col);
        item.element_value = value;
        send_item(item);
    endtask

    task automatic drain_c_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_c_elems.size() != 0);
    endtask

    // Waits for every expected element of C and then for a full row time more
    // before touching the size register.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain_c_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = value;
        size_writes++;
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] value, input int count,
                             input int gap_max, input int stall);
        int n;
        write_size(value);
        n          = eff_size(value);
        gap_limit  = gap_max;
        stall_pct  = stall;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_c_results();
            send_item(pick_item(n));
        end
    endtask

    task automatic test_directed_cases();
        gap_limit = 0;
        stall_pct = 0;
        write_size(1);
        // Most negative times minus one wraps back to the most negative value.
        send_op(ACT_WRITE_A, 0, 0, MIN_NEG);
        send_op(ACT_WRITE_B, 0, 0, ALL_ONES);
        send_op(ACT_EMIT, 0, 15, 32'h1234_5678);
        send_op(ACT_EMIT, 15, 0, '0);
        send_op(ACT_UNUSED, 15, 15, MAX_POS);
        // Stored beyond the active size, read later at larger sizes.
        send_op(ACT_WRITE_A, 15, 15, MAX_POS);
        send_op(ACT_WRITE_B, 15, 15, MAX_POS);
        // A size of zero behaves as one.
        write_size(0);
        send_op(ACT_EMIT, 0, 0, '0);
        send_op(ACT_EMIT, 1, 0, '0);
        write_size(2);
        send_op(ACT_WRITE_A, 0, 1, MAX_POS);
        send_op(ACT_WRITE_A, 1, 0, 32'd1);
        send_op(ACT_WRITE_A, 1, 1, ALL_ONES);
        send_op(ACT_WRITE_B, 0, 1, 32'd2);
        send_op(ACT_WRITE_B, 1, 0, MAX_POS);
        send_op(ACT_WRITE_B, 1, 1, MIN_NEG);
        send_op(ACT_EMIT, 1, 3, ALL_ONES);
        send_op(ACT_EMIT, 0, 0, '0);
    endtask

    task automatic test_growing_sizes();
        run_phase(5'd3, 30, 0, 0);
        run_phase(5'd7, 40, 4, 20);
        run_phase(5'd12, 70, 2, 30);
        run_phase(5'd16, 180, 6, 40);
        run_phase(5'd31, 60, 0, 0);
    endtask

    task automatic test_mixed_sizes();
        run_phase(SIZE_W'($urandom_range(2, DIM - 1)), 30, 10, 50);
        run_phase(5'd1, 20, 3, 60);
        run_phase(SIZE_W'($urandom_range(2, DIM - 1)), 30, 0, 25);
    endtask

    // Receiver stalls only in every other window of stall_phase, while its bit 5 is set.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_phase <= stall_phase + 8'd1;
            out_stall   <= stall_pct != 0 && stall_phase[5] &&
                           $urandom_range(0, 99) < stall_pct;
        end
    end

    always @(posedge clk)
    begin : check_results
        imm_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_c_elems.size() == 0)
                report_error($sformatf("Unexpected result: col %0d value %0d last %0b",
                                       out_data.out_col, out_data.out_value,
                                       out_data.row_last));
            else
            begin
                want = expected_c_elems.pop_front();
                if (want.out_col !== out_data.out_col || want.out_value !== out_data.out_value
                    || want.row_last !== out_data.row_last)
                    report_error($sformatf(
                        "Result mismatch: expected col %0d value %0d last %0b, got col %0d value %0d last %0b",
                        want.out_col, want.out_value, want.row_last,
                        out_data.out_col, out_data.out_value, out_data.row_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_growing_sizes();
        test_mixed_sizes();
        drain_c_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d input transactions and checked %0d row elements of C",
                 items_sent, results_seen);
        $display("across %0d size settings, from zero and one up to the full size and beyond.",
                 size_writes);
        if (mismatches == 0 && expected_c_elems.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
